[hdl/lrut_pkg.sv]
// ----------------------------------------------------------------------------
// lrut_pkg: shared types and constants for the LRU hit tracker
// Field widths, reset value of the ways register and the control bundle
// that the top level broadcasts to every cell of the recency stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrut_pkg;

  // Key width and ways register width are fixed by the interface
  localparam int unsigned KeyW  = 32;
  localparam int unsigned WaysW = 7;

  localparam logic [WaysW-1:0] WaysReset = 7'd64;

  // Broadcast control to each cell
  typedef struct packed {
    logic upd;     // a request is accepted: recency stack moves this cycle
    logic hit;     // the key matched some valid entry in use
    logic cfg_we;  // ways register is written this cycle
  } lrut_ctrl_t;

endpackage

[hdl/lru_cache_hit_tracker_unit.sv]
// Latency: the hit flag is shown in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is empty or its result is
// taken; the compare across all cells and the match chain are combinational and the recency stack shifts one position.
// Reset: all valid bits cleared, ways register set to 64, output empty.
// ----------------------------------------------------------------------------
// lru_cache_hit_tracker_unit: fully associative LRU cache hit tracker
// A chain of CAPACITY cells forms the recency stack, position 0 most recent.
// Each request compares its key in every cell; hit or miss moves the stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_cache_hit_tracker_unit import lrut_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KeyW-1:0]  key_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             hit_o,
  input  logic             cfg_we_i,
  input  logic [WaysW-1:0] cfg_wdata_i
);

  localparam int unsigned NW = $clog2(CAPACITY + 1);

  // Ways count clamped to 1..CAPACITY
  function automatic logic [NW-1:0] eff_ways(logic [WaysW-1:0] w);
    logic [31:0] w32;
    logic [31:0] res;
    w32 = 32'(w);
    res = w32;
    if (w32 == 32'd0) begin
      res = 32'd1;
    end else if (w32 > 32'(CAPACITY)) begin
      res = 32'(CAPACITY);
    end
    return res[NW-1:0];
  endfunction

  logic [WaysW-1:0] ways_q;
  logic [NW-1:0]    eff_cur, eff_new;
  logic             accept;
  logic             out_valid_q, out_valid_d;
  logic             hit_q;
  lrut_ctrl_t       ctrl;

  logic [KeyW-1:0] cell_key   [CAPACITY];
  logic [KeyW-1:0] prev_key   [CAPACITY];
  logic            prev_valid [CAPACITY];
  logic [CAPACITY-1:0] cell_valid, in_use, keep, match;
  logic [CAPACITY:0]   seen;

  // Ways register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= WaysReset;
    end else if (cfg_we_i) begin
      ways_q <= cfg_wdata_i;
    end
  end

  assign eff_cur = eff_ways(ways_q);
  assign eff_new = eff_ways(cfg_wdata_i);

  // Request handshake: output register parts the two sides
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign seen[0]    = 1'b0;
  assign ctrl.upd   = accept;
  assign ctrl.hit   = seen[CAPACITY];
  assign ctrl.cfg_we = cfg_we_i;

  // Recency stack
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_key[i]   = key_i;
      assign prev_valid[i] = 1'b1;
    end else begin : g_body
      assign prev_key[i]   = cell_key[i-1];
      assign prev_valid[i] = cell_valid[i-1];
    end
    assign in_use[i] = NW'(i) < eff_cur;
    assign keep[i]   = NW'(i) < eff_new;

    lrut_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_i),
      .in_use_i     (in_use[i]),
      .keep_i       (keep[i]),
      .prev_key_i   (prev_key[i]),
      .prev_valid_i (prev_valid[i]),
      .seen_i       (seen[i]),
      .key_o        (cell_key[i]),
      .valid_o      (cell_valid[i]),
      .seen_o       (seen[i+1]),
      .match_o      (match[i])
    );
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q <= ctrl.hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  // A key is held by at most one valid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match))
    else $error("duplicate key in recency stack");

  // Valid entries only live in positions in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & ~in_use) == '0)
    else $error("valid entry beyond ways in use");

  // Accepted key lands valid at the most recent position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i |=> cell_valid[0] && cell_key[0] == $past(key_i))
    else $error("head of stack not updated");

  // Every accepted request yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o && hit_o == $past(ctrl.hit))
    else $error("result not presented");

endmodule

[hdl/lrut_cell.sv]
// ----------------------------------------------------------------------------
// lrut_cell: one position of the recency stack
// Holds a key and its valid bit, compares against the broadcast key and
// takes the contents of the more recent neighbour when the stack shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrut_cell import lrut_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lrut_ctrl_t      ctrl_i,
  input  logic [KeyW-1:0] key_i,        // broadcast lookup key
  input  logic            in_use_i,     // position below the current ways count
  input  logic            keep_i,       // position below the ways count being written
  input  logic [KeyW-1:0] prev_key_i,   // contents of the more recent neighbour
  input  logic            prev_valid_i,
  input  logic            seen_i,       // match found at a more recent position
  output logic [KeyW-1:0] key_o,
  output logic            valid_o,
  output logic            seen_o,
  output logic            match_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic            valid_q, valid_d;
  logic            shift;

  // Associative compare
  assign match_o = valid_q && in_use_i && (key_q == key_i);
  assign seen_o  = seen_i | match_o;

  // On a hit positions up to the matching one shift; on a miss all in use
  assign shift = ctrl_i.hit ? !seen_i : in_use_i;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.upd && shift) begin
      key_d   = prev_key_i;
      valid_d = prev_valid_i;
    end
    if (ctrl_i.cfg_we && !keep_i) begin
      valid_d = 1'b0;
    end
  end

  // Key is payload only, no reset needed
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule
